// ----- src/amct_pkg.sv -----
// ----------------------------------------------------------------------------
// Adjacency matrix compacting table package
// Shared constants, command codes and state encoding for the table.
// ----------------------------------------------------------------------------
package amct_pkg;

  // Default node capacity of the table.
  localparam int MAX_NODES_DEF = 32;

  // Field widths fixed by the command and result interface.
  localparam int CMD_W       = 2;
  localparam int INDEX_IN_W  = 8;
  localparam int NEW_INDEX_W = 5;
  localparam int COUNT_OUT_W = 6;

  // Command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SET    = 2'd2,
    CMD_GET    = 2'd3
  } cmd_t;

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SWEEP = 4'b0010,
    ST_LINK  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  // Steps of a link access.
  localparam logic [1:0] PH_READ_A  = 2'd0;
  localparam logic [1:0] PH_WRITE_A = 2'd1;
  localparam logic [1:0] PH_WRITE_B = 2'd2;

endpackage

// ----- src/adjacency_matrix_compacting_table_top.sv -----
// ----------------------------------------------------------------------------
// Adjacency matrix compacting table
// Symmetric node link matrix held in one row memory, with a live node count.
// ----------------------------------------------------------------------------
// Add and remove run one memory sweep over all rows, read and write-back
//   overlapped. Set runs two row read-modify-writes and get one row
//   read; a rejected command goes straight to the result. One command
//   is in work at a time.
// The rate is set by the single read and single write port of the row memory.
// Reset clears the per-row valid bits and the count: no sweep.
module adjacency_matrix_compacting_table_top #(
  parameter int MAX_NODES = amct_pkg::MAX_NODES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Command channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [amct_pkg::CMD_W-1:0]         in_command,
  input  logic [amct_pkg::INDEX_IN_W-1:0]    in_first_index,
  input  logic [amct_pkg::INDEX_IN_W-1:0]    in_second_index,
  input  logic                               in_link_value,
  // Result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_status,
  output logic [amct_pkg::NEW_INDEX_W-1:0]   out_new_index,
  output logic                               out_adjacent,
  output logic [amct_pkg::COUNT_OUT_W-1:0]   out_node_count
);

  localparam int IW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam logic [MAX_NODES-1:0] ALL_ONES = {MAX_NODES{1'b1}};
  localparam logic [MAX_NODES-1:0] ONE_HOT0 = {{(MAX_NODES-1){1'b0}}, 1'b1};

  // Control and operand registers.
  amct_pkg::state_t state_r, state_nxt;
  amct_pkg::cmd_t   cmd_r, cmd_nxt;
  logic [IW-1:0]    a_r, a_nxt;
  logic [IW-1:0]    b_r, b_nxt;
  logic             v_r, v_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [1:0]       ph_r, ph_nxt;

  // Sweep sequencing.
  logic [IW-1:0]    sw_r, sw_nxt;
  logic             sw_issue_r, sw_issue_nxt;
  logic [IW-1:0]    wr_row_r, wr_row_nxt;
  logic             wr_pend_r, wr_pend_nxt;

  // Pending result.
  logic                               res_status_r, res_status_nxt;
  logic [amct_pkg::NEW_INDEX_W-1:0]   res_new_r, res_new_nxt;
  logic                               res_adj_r, res_adj_nxt;

  // Output register.
  logic                               out_valid_r, out_valid_nxt;
  logic                               out_status_r;
  logic [amct_pkg::NEW_INDEX_W-1:0]   out_new_index_r;
  logic                               out_adjacent_r;
  logic [amct_pkg::COUNT_OUT_W-1:0]   out_node_count_r;
  logic                               out_load;

  // Row memory and its ports.
  logic [MAX_NODES-1:0] mem [MAX_NODES];
  logic [MAX_NODES-1:0] row_valid_r;
  logic [MAX_NODES-1:0] rd_data_r;
  logic                 rowv_q_r;
  logic [MAX_NODES-1:0] rd_row;
  logic                 rd_en;
  logic [IW-1:0]        rd_addr;
  logic                 wr_en;
  logic [IW-1:0]        wr_addr;
  logic [MAX_NODES-1:0] wr_data;

  // Sweep data paths.
  logic [MAX_NODES-1:0] add_data;
  logic [MAX_NODES-1:0] low_a;
  logic [MAX_NODES-1:0] live_mask;
  logic [MAX_NODES-1:0] rem_data;
  logic [IW-1:0]        sw_src;
  logic                 link_bad;

  assign in_ready       = (state_r == amct_pkg::ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_new_index  = out_new_index_r;
  assign out_adjacent   = out_adjacent_r;
  assign out_node_count = out_node_count_r;

  // A row never written since reset reads as all zero.
  assign rd_row = rowv_q_r ? rd_data_r : '0;

  // Add clears the new node's column in every row and its whole row.
  assign add_data = (wr_row_r == a_r) ? '0 : (rd_row & ~(ONE_HOT0 << a_r));

  // Remove drops column a by shifting the higher columns down one place,
  // then clears everything outside the remaining live square.
  assign low_a     = ~(ALL_ONES << a_r);
  assign live_mask = ~(ALL_ONES << cnt_r);
  assign rem_data  = (8'(wr_row_r) >= 8'(cnt_r)) ? '0 :
                     (((rd_row & low_a) | ((rd_row >> 1) & ~low_a)) & live_mask);

  // Source row of a sweep read: remove skips the deleted row.
  assign sw_src = (cmd_r == amct_pkg::CMD_REMOVE && sw_r >= a_r) ? IW'(sw_r + 1'b1) : sw_r;

  // Link commands reject equal indices and indices beyond capacity.
  assign link_bad = (in_first_index == in_second_index) ||
                    ({1'b0, in_first_index} >= 9'(MAX_NODES)) ||
                    ({1'b0, in_second_index} >= 9'(MAX_NODES));

  assign out_load = (state_r == amct_pkg::ST_DONE) && (!out_valid_r || out_ready);

  // Sequencer: command decode, row sweeps and link read-modify-writes.
  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    v_nxt          = v_r;
    cnt_nxt        = cnt_r;
    ph_nxt         = ph_r;
    sw_nxt         = sw_r;
    sw_issue_nxt   = sw_issue_r;
    wr_row_nxt     = wr_row_r;
    wr_pend_nxt    = wr_pend_r;
    res_status_nxt = res_status_r;
    res_new_nxt    = res_new_r;
    res_adj_nxt    = res_adj_r;
    rd_en          = 1'b0;
    rd_addr        = '0;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = '0;
    case (state_r)
      amct_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt        = amct_pkg::cmd_t'(in_command);
          b_nxt          = in_second_index[IW-1:0];
          v_nxt          = in_link_value;
          res_status_nxt = 1'b0;
          res_new_nxt    = '0;
          res_adj_nxt    = 1'b0;
          sw_nxt         = '0;
          sw_issue_nxt   = 1'b1;
          wr_pend_nxt    = 1'b0;
          ph_nxt         = amct_pkg::PH_READ_A;
          case (amct_pkg::cmd_t'(in_command))
            amct_pkg::CMD_ADD: begin
              if (cnt_r >= CW'(MAX_NODES)) begin
                res_status_nxt = 1'b1;
                state_nxt      = amct_pkg::ST_DONE;
              end else begin
                a_nxt       = cnt_r[IW-1:0];
                res_new_nxt = amct_pkg::NEW_INDEX_W'(cnt_r);
                cnt_nxt     = CW'(cnt_r + 1'b1);
                state_nxt   = amct_pkg::ST_SWEEP;
              end
            end
            amct_pkg::CMD_REMOVE: begin
              if ({1'b0, in_first_index} >= 9'(cnt_r)) begin
                res_status_nxt = 1'b1;
                state_nxt      = amct_pkg::ST_DONE;
              end else begin
                a_nxt     = in_first_index[IW-1:0];
                cnt_nxt   = CW'(cnt_r - 1'b1);
                state_nxt = amct_pkg::ST_SWEEP;
              end
            end
            default: begin
              if (link_bad) begin
                res_status_nxt = 1'b1;
                state_nxt      = amct_pkg::ST_DONE;
              end else begin
                a_nxt     = in_first_index[IW-1:0];
                state_nxt = amct_pkg::ST_LINK;
              end
            end
          endcase
        end
      end
      amct_pkg::ST_SWEEP: begin
        // Read one row a cycle; write back the row read in the cycle before.
        if (sw_issue_r) begin
          rd_en       = 1'b1;
          rd_addr     = sw_src;
          wr_row_nxt  = sw_r;
          wr_pend_nxt = 1'b1;
          if (sw_r == IW'(MAX_NODES - 1)) begin
            sw_issue_nxt = 1'b0;
          end else begin
            sw_nxt = IW'(sw_r + 1'b1);
          end
        end else begin
          wr_pend_nxt = 1'b0;
        end
        if (wr_pend_r) begin
          wr_en   = 1'b1;
          wr_addr = wr_row_r;
          wr_data = (cmd_r == amct_pkg::CMD_ADD) ? add_data : rem_data;
          if (!sw_issue_r) begin
            state_nxt = amct_pkg::ST_DONE;
          end
        end
      end
      amct_pkg::ST_LINK: begin
        case (ph_r)
          amct_pkg::PH_READ_A: begin
            rd_en   = 1'b1;
            rd_addr = a_r;
            ph_nxt  = amct_pkg::PH_WRITE_A;
          end
          amct_pkg::PH_WRITE_A: begin
            if (cmd_r == amct_pkg::CMD_GET) begin
              res_adj_nxt = rd_row[b_r];
              state_nxt   = amct_pkg::ST_DONE;
            end else begin
              wr_en         = 1'b1;
              wr_addr       = a_r;
              wr_data       = rd_row;
              wr_data[b_r]  = v_r;
              rd_en         = 1'b1;
              rd_addr       = b_r;
              ph_nxt        = amct_pkg::PH_WRITE_B;
            end
          end
          default: begin
            wr_en        = 1'b1;
            wr_addr      = b_r;
            wr_data      = rd_row;
            wr_data[a_r] = v_r;
            state_nxt    = amct_pkg::ST_DONE;
          end
        endcase
      end
      amct_pkg::ST_DONE: begin
        if (out_load) begin
          state_nxt = amct_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = amct_pkg::ST_IDLE;
      end
    endcase
  end

  // Output register holds a finished result until its transfer.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= amct_pkg::ST_IDLE;
      cnt_r       <= '0;
      sw_issue_r  <= 1'b0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
      row_valid_r <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sw_issue_r  <= sw_issue_nxt;
      wr_pend_r   <= wr_pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (wr_en) begin
        row_valid_r[wr_addr] <= 1'b1;
      end
    end
  end

  // Operand, sequencing and result payload.
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    v_r          <= v_nxt;
    ph_r         <= ph_nxt;
    sw_r         <= sw_nxt;
    wr_row_r     <= wr_row_nxt;
    res_status_r <= res_status_nxt;
    res_new_r    <= res_new_nxt;
    res_adj_r    <= res_adj_nxt;
    if (out_load) begin
      out_status_r     <= res_status_r;
      out_new_index_r  <= res_new_r;
      out_adjacent_r   <= res_adj_r;
      out_node_count_r <= amct_pkg::COUNT_OUT_W'(cnt_r);
    end
  end

  // Row memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rowv_q_r  <= row_valid_r[rd_addr];
    end
  end

  // The schedule never reads and writes the same row in one cycle.
  a_no_rw_collision : assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("row read and write collide");

  // The node count never exceeds the capacity.
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_NODES))
    else $error("node count beyond capacity");

  // Once reads stop, the sweep still owes the last write-back.
  a_sweep_tail : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == amct_pkg::ST_SWEEP && !sw_issue_r) |-> wr_pend_r)
    else $error("sweep ended without final write");

  // A transfer on the command channel starts work; no second command follows at once.
  a_one_at_a_time : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("command taken while one is in work");

endmodule
